/* rtl/ftab_pkg.sv */
// ----------------------------------------------------------------------------
// ftab_pkg
// Types and constants shared by the IPv4 flow meter table.
// ----------------------------------------------------------------------------
package ftab_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned FIFO_DEPTH      = 4;

	localparam logic [31:0] INACT_RESET = 32'd15000;
	localparam logic [31:0] ACT_RESET   = 32'd1800000;

	localparam logic       REG_INACT = 1'b0;
	localparam logic       REG_ACT   = 1'b1;

	localparam logic [7:0] ETH_IPV4_HI = 8'h08;
	localparam logic [7:0] ETH_IPV4_LO = 8'h00;
	localparam logic [7:0] IP_VER_MASK = 8'hf0;
	localparam logic [7:0] IP_VER_4    = 8'h40;
	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] FIN_RST     = 8'h05;
	localparam logic [7:0] STRB_FULL   = 8'hff;
	localparam logic [7:0] STRB_LAST   = 8'h7f;

	// emit sequence positions
	localparam logic [3:0] EMIT_A0   = 4'd0;
	localparam logic [3:0] EMIT_A3   = 4'd3;
	localparam logic [3:0] EMIT_B0   = 4'd4;
	localparam logic [3:0] EMIT_B3   = 4'd7;
	localparam logic [3:0] EMIT_STAT = 4'd8;

	typedef struct packed {
		logic [63:0] beat_data;
		logic        beat_last;
		logic [31:0] now_ms;
	} beat_t;

	typedef struct packed {
		logic [63:0] word;
		logic [7:0]  strobe_res;
		logic        record_end;
		logic        is_status;
		logic [31:0] processed_packets;
		logic [31:0] collisions;
		logic        run_end;
	} res_t;

	typedef struct packed {
		logic [31:0] inactive_timeout_ms;
		logic [31:0] active_timeout_ms;
	} cfg_t;

	// one packet summary, front to back
	typedef struct packed {
		logic        cap;
		logic [31:0] ts;
		logic [15:0] len;
		logic [7:0]  proto;
		logic [63:0] ips;
		logic [31:0] ports;
		logic [7:0]  flag_bits;
	} desc_t;

	typedef struct packed {
		logic [63:0] addrs;
		logic [39:0] pp;
		logic [63:0] times;
		logic [63:0] counts;
		logic [7:0]  flags;
	} entry_t;

endpackage

/* rtl/ftab_front.sv */
// ----------------------------------------------------------------------------
// ftab_front
// Header capture: pulls the 5-tuple, length, flags and time from each packet.
// ----------------------------------------------------------------------------
module ftab_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  ftab_pkg::beat_t  beat,
	output logic             push,
	output ftab_pkg::desc_t  desc
);

	logic [2:0]  idx_q;
	logic        drop_q, done_q;
	logic [31:0] ts_q;
	logic [15:0] len_q;
	logic [7:0]  proto_q, flags_q;
	logic [63:0] ips_q;
	logic [31:0] ports_q;

	logic        n_drop, n_done;
	logic [31:0] n_ts;
	logic [15:0] n_len;
	logic [7:0]  n_proto, n_flags;
	logic [63:0] n_ips;
	logic [31:0] n_ports;
	logic [7:0]  b [8];

	always_comb begin
		for (int i = 0; i < 8; i++) b[i] = beat.beat_data[8*i +: 8];
		n_drop = drop_q; n_done = done_q; n_ts = ts_q; n_len = len_q;
		n_proto = proto_q; n_flags = flags_q; n_ips = ips_q; n_ports = ports_q;
		if (!drop_q && !done_q) begin
			case (idx_q)
				3'd0: n_ts = beat.now_ms;
				3'd1: begin
					if (b[4] != ftab_pkg::ETH_IPV4_HI || b[5] != ftab_pkg::ETH_IPV4_LO ||
					    (b[6] & ftab_pkg::IP_VER_MASK) != ftab_pkg::IP_VER_4)
						n_drop = 1'b1;
				end
				3'd2: begin
					n_len   = {b[0], b[1]};
					n_proto = b[7];
					if (b[7] != ftab_pkg::PROTO_TCP && b[7] != ftab_pkg::PROTO_UDP)
						n_drop = 1'b1;
				end
				3'd3: n_ips = {b[2], b[3], b[4], b[5], b[6], b[7], 16'h0};
				3'd4: begin
					n_ips   = {ips_q[63:16], b[0], b[1]};
					n_ports = {b[2], b[3], b[4], b[5]};
				end
				3'd5: begin
					n_flags = (proto_q == ftab_pkg::PROTO_TCP) ? b[7] : 8'h0;
					n_done  = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign push = accept && beat.beat_last;
	assign desc = '{cap: n_done, ts: n_ts, len: n_len, proto: n_proto, ips: n_ips,
	                ports: n_ports, flag_bits: n_flags};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			drop_q <= 1'b0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (beat.beat_last) begin
				idx_q  <= '0;
				drop_q <= 1'b0;
				done_q <= 1'b0;
			end else begin
				if (idx_q != 3'd7) idx_q <= idx_q + 3'd1;
				drop_q <= n_drop;
				done_q <= n_done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q    <= n_ts;
			len_q   <= n_len;
			proto_q <= n_proto;
			flags_q <= n_flags;
			ips_q   <= n_ips;
			ports_q <= n_ports;
		end
	end

endmodule

/* rtl/ftab_fifo.sv */
// ----------------------------------------------------------------------------
// ftab_fifo
// Short packet-summary queue between capture and table update.
// ----------------------------------------------------------------------------
module ftab_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ftab_pkg::desc_t  din,
	input  logic             pop,
	output ftab_pkg::desc_t  dout,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PW = $clog2(ftab_pkg::FIFO_DEPTH);

	ftab_pkg::desc_t mem_q [ftab_pkg::FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(ftab_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

/* rtl/ftab_back.sv */
// ----------------------------------------------------------------------------
// ftab_back
// Flow table: hash reduce, timeout scan, merge, and record emission.
// ----------------------------------------------------------------------------
module ftab_back #(
	parameter int unsigned TABLE_DEPTH = ftab_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ftab_pkg::cfg_t   cfg,
	input  ftab_pkg::desc_t  desc,
	input  logic             desc_avail,
	output logic             desc_pop,
	output logic             clearing,
	output logic             res_valid,
	input  logic             res_ready,
	output ftab_pkg::res_t   res
);

	localparam int unsigned AW   = $clog2(TABLE_DEPTH);
	// reciprocal of the depth, exact for any 16-bit hash
	localparam int unsigned RSH  = 16 + AW;
	localparam logic [17:0] RMUL = 18'(((64'd1 << RSH) + 64'(TABLE_DEPTH) - 64'd1) /
	                                   64'(TABLE_DEPTH));

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RED   = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_EVAL  = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q, scan_q;
	logic [31:0]     pkt_q, coll_q, coll_rep_q;
	ftab_pkg::desc_t desc_q;
	logic [15:0]     rem_q;
	logic [15:0]     quot_q;
	logic            k_q;
	logic            store_q, fin_q, exp_a_q, exp_b_q;
	ftab_pkg::entry_t new_q, recb_q;
	logic [3:0]      idx_q;
	logic            res_valid_q;
	ftab_pkg::res_t  res_q;

	logic             vmem [TABLE_DEPTH];
	ftab_pkg::entry_t dmem [TABLE_DEPTH];
	logic             va_q, vb_q;
	ftab_pkg::entry_t rda_q, rdb_q;

	logic [AW-1:0]   addr_a;
	logic            v_we, v_wd, d_we;
	logic [AW-1:0]   v_wa;
	logic [15:0]     hash;
	logic [33:0]     prod;
	logic [16:0]     dsub;
	logic            b_exp, av, match, collide, fin, store;
	logic [39:0]     pp;
	ftab_pkg::entry_t new_e, rec;
	logic [63:0]     w;
	logic [3:0]      idx_n;
	logic            load;

	assign addr_a = rem_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_wa] <= v_wd;
		if (d_we) dmem[v_wa] <= new_q;
		va_q  <= vmem[addr_a];
		vb_q  <= vmem[scan_q];
		rda_q <= dmem[addr_a];
		rdb_q <= dmem[scan_q];
	end

	assign hash = desc.ips[63:48] ^ desc.ips[47:32] ^ desc.ips[31:16] ^ desc.ips[15:0] ^
	              desc.ports[31:16] ^ desc.ports[15:0] ^ {8'h0, desc.proto};
	assign prod = 34'(rem_q) * 34'(RMUL);
	assign dsub = 17'(quot_q) * 17'(TABLE_DEPTH);

	always_comb begin
		pp = {desc_q.proto, desc_q.ports};
		// scan happens before the merge, so a same-slot expiry frees the slot first
		b_exp = vb_q && ((desc_q.ts - rdb_q.times[63:32]) >= cfg.inactive_timeout_ms ||
		                 (desc_q.ts - rdb_q.times[31:0]) >= cfg.active_timeout_ms);
		av      = va_q && !((addr_a == scan_q) && b_exp);
		match   = (rda_q.addrs == desc_q.ips) && (rda_q.pp == pp);
		collide = desc_q.cap && av && !match;
		fin     = (desc_q.flag_bits & ftab_pkg::FIN_RST) != 8'h0;
		store   = desc_q.cap && !collide;
		new_e.addrs = desc_q.ips;
		new_e.pp    = pp;
		if (av) begin
			new_e.times  = {desc_q.ts, rda_q.times[31:0]};
			new_e.counts = {rda_q.counts[63:32] + {16'h0, desc_q.len},
			                rda_q.counts[31:0] + 32'd1};
			new_e.flags  = rda_q.flags | desc_q.flag_bits;
		end else begin
			new_e.times  = {desc_q.ts, desc_q.ts};
			new_e.counts = {16'h0, desc_q.len, 32'd1};
			new_e.flags  = desc_q.flag_bits;
		end
	end

	always_comb begin
		v_we = 1'b0; v_wd = 1'b0; v_wa = clr_q; d_we = 1'b0;
		unique case (state_q)
			ST_CLEAR: v_we = 1'b1;
			ST_EVAL: begin
				v_we = b_exp;
				v_wa = scan_q;
			end
			ST_WR: begin
				v_we = store_q;
				v_wa = addr_a;
				v_wd = !fin_q;
				d_we = store_q && !fin_q;
			end
			default: ;
		endcase
	end

	// emit sequence
	always_comb begin
		rec = idx_q[2] ? recb_q : new_q;
		case (idx_q[1:0])
			2'd0:    w = rec.counts;
			2'd1:    w = rec.times;
			2'd2:    w = rec.addrs;
			default: w = {16'h0, rec.flags, rec.pp};
		endcase
		if (idx_q == ftab_pkg::EMIT_A3)      idx_n = exp_b_q ? ftab_pkg::EMIT_B0 : ftab_pkg::EMIT_STAT;
		else if (idx_q == ftab_pkg::EMIT_B3) idx_n = ftab_pkg::EMIT_STAT;
		else                                 idx_n = idx_q + 4'd1;
		load = (state_q == ST_EMIT) && (!res_valid_q || res_ready);
	end

	assign desc_pop  = (state_q == ST_IDLE) && desc_avail;
	assign clearing  = (state_q == ST_CLEAR);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			pkt_q       <= '0;
			coll_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load)           res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (desc_avail) state_q <= ST_RED;
				ST_RED:  if (!k_q) state_q <= ST_RD;
				ST_RD:   state_q <= ST_EVAL;
				ST_EVAL: begin
					pkt_q  <= pkt_q + 32'd1;
					coll_q <= coll_q + 32'(collide);
					scan_q <= (scan_q == AW'(TABLE_DEPTH - 1)) ? '0 : scan_q + 1'b1;
					state_q <= ST_WR;
				end
				ST_WR:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load && idx_q == ftab_pkg::EMIT_STAT) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			desc_q <= desc;
			rem_q  <= hash;
			k_q    <= 1'b1;
		end
		// hash modulo table depth: quotient by reciprocal, then subtract
		if (state_q == ST_RED) begin
			if (k_q) quot_q <= 16'(prod >> RSH);
			else     rem_q  <= rem_q - dsub[15:0];
			k_q <= 1'b0;
		end
		if (state_q == ST_EVAL) begin
			new_q      <= new_e;
			recb_q     <= rdb_q;
			store_q    <= store;
			fin_q      <= fin;
			exp_a_q    <= store && fin;
			exp_b_q    <= b_exp;
			coll_rep_q <= coll_q;
		end
		if (state_q == ST_WR)
			idx_q <= exp_a_q ? ftab_pkg::EMIT_A0 :
			         (exp_b_q ? ftab_pkg::EMIT_B0 : ftab_pkg::EMIT_STAT);
		if (load) begin
			idx_q <= idx_n;
			if (idx_q == ftab_pkg::EMIT_STAT) begin
				res_q <= '{word: 64'h0, strobe_res: 8'h0, record_end: 1'b0, is_status: 1'b1,
				           processed_packets: pkt_q, collisions: coll_rep_q, run_end: 1'b1};
			end else begin
				res_q <= '{word: w,
				           strobe_res: (idx_q[1:0] == 2'd3) ? ftab_pkg::STRB_LAST
				                                            : ftab_pkg::STRB_FULL,
				           record_end: (idx_q[1:0] == 2'd3), is_status: 1'b0,
				           processed_packets: 32'h0, collisions: 32'h0, run_end: 1'b0};
			end
		end
	end

endmodule

/* rtl/ipv4_flow_meter_table.sv */
// ----------------------------------------------------------------------------
// ipv4_flow_meter_table
// IPv4 TCP/UDP flow cache with timeout scan and four-word export records.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// beat      beat_valid / beat_ready   beat  (beat_data, beat_last, now_ms)
// res       res_valid / res_ready     res   (record words, status)
// config    cfg_we                    cfg_index, cfg_data
//
// Beats are taken one per cycle while the summary queue has room.
// Each packet runs the table side through reduce, read, evaluate and write,
// then its results (records and status, up to nine) as res_ready allows.
// After reset the valid store is cleared entry by entry, with beat_ready low.
// Either side may stall; the four-entry queue decouples them.
// ----------------------------------------------------------------------------
module ipv4_flow_meter_table #(
	parameter int unsigned TABLE_DEPTH = ftab_pkg::TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            beat_valid,
	output logic            beat_ready,
	input  ftab_pkg::beat_t beat,
	output logic            res_valid,
	input  logic            res_ready,
	output ftab_pkg::res_t  res,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data
);

	ftab_pkg::cfg_t  cfg_q;
	ftab_pkg::desc_t f_desc, q_desc;
	logic            accept, push, pop, full, empty, clearing;

	assign beat_ready = !clearing && !full;
	assign accept     = beat_valid && beat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inactive_timeout_ms <= ftab_pkg::INACT_RESET;
			cfg_q.active_timeout_ms   <= ftab_pkg::ACT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftab_pkg::REG_INACT: cfg_q.inactive_timeout_ms <= cfg_data;
				ftab_pkg::REG_ACT:   cfg_q.active_timeout_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	ftab_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .beat(beat),
		.push(push), .desc(f_desc)
	);

	ftab_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(f_desc), .pop(pop),
		.dout(q_desc), .full(full), .empty(empty)
	);

	ftab_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .desc(q_desc), .desc_avail(!empty),
		.desc_pop(pop), .clearing(clearing), .res_valid(res_valid),
		.res_ready(res_ready), .res(res)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("summary queue overflow");

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_status |-> res.run_end && !res.record_end)
		else $error("status item not marked as run end");

	a_rec_end_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.record_end |-> res.strobe_res == ftab_pkg::STRB_LAST)
		else $error("record end with wrong strobe");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

endmodule

/* bench/flow_meter_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_meter_scoreboard
// Watches the beat, result and register ports of the flow meter table, keeps
// its own copy of the flow cache, predicts export records and status words
// per packet and compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module flow_meter_scoreboard
	import ftab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        beat_valid,
	input  logic        beat_ready,
	input  beat_t       beat,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          packets_seen,
	output int          records_seen,
	output int          collisions_seen
);

	localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

	logic [31:0] inact_ms, act_ms;
	logic [DEPTH-1:0] slot_used;
	entry_t      flow_tab [DEPTH];
	logic [31:0] pkt_count, coll_count;
	int unsigned scan_ptr;
	logic [2:0]  beat_pos;
	logic        dropping, captured;
	logic [31:0] c_ts;
	logic [15:0] c_len;
	logic [7:0]  c_proto, c_flags;
	logic [63:0] c_ips;
	logic [31:0] c_ports;

	res_t expected_res[$];

	function automatic logic [7:0] byte_of(input logic [63:0] d, input int n);
		return d[8*n +: 8];
	endfunction

	task automatic push_record(input entry_t e);
		res_t r;
		for (int i = 0; i < 4; i++) begin
			r = '0;
			case (i)
				0: r.word = e.counts;
				1: r.word = e.times;
				2: r.word = e.addrs;
				default: r.word = {16'h0, e.flags, e.pp};
			endcase
			r.strobe_res = (i == 3) ? STRB_LAST : STRB_FULL;
			r.record_end = (i == 3);
			expected_res.push_back(r);
		end
	endtask

	// one accepted beat; on the last beat of a packet, the table update
	task automatic meter_beat(input beat_t b);
		logic [63:0] d;
		logic [9:0]  s, a;
		logic [15:0] h;
		logic [39:0] pp;
		logic [31:0] src, dst, bytes, pkts;
		logic        scan_exp, hit_exp, store, fin;
		logic [31:0] prior_coll;
		entry_t      scan_e, e;
		res_t        st;
		d = b.beat_data;
		if (!dropping && !captured) begin
			case (beat_pos)
				3'd0: c_ts = b.now_ms;
				3'd1: if (byte_of(d, 4) != ETH_IPV4_HI || byte_of(d, 5) != ETH_IPV4_LO ||
						(byte_of(d, 6) & IP_VER_MASK) != IP_VER_4)
						dropping = 1'b1;
				3'd2: begin
					c_len = {byte_of(d, 0), byte_of(d, 1)};
					c_proto = byte_of(d, 7);
					if (c_proto != PROTO_TCP && c_proto != PROTO_UDP)
						dropping = 1'b1;
				end
				3'd3: c_ips = {byte_of(d, 2), byte_of(d, 3), byte_of(d, 4), byte_of(d, 5),
						byte_of(d, 6), byte_of(d, 7), 16'h0};
				3'd4: begin
					c_ips[15:0] = {byte_of(d, 0), byte_of(d, 1)};
					c_ports = {byte_of(d, 2), byte_of(d, 3), byte_of(d, 4), byte_of(d, 5)};
				end
				3'd5: begin
					c_flags = (c_proto == PROTO_TCP) ? byte_of(d, 7) : 8'h0;
					captured = 1'b1;
				end
				default: ;
			endcase
		end
		if (beat_pos < 3'd7)
			beat_pos++;
		if (!b.beat_last)
			return;

		// timeout scan sees the table before this packet
		s = 10'(scan_ptr % DEPTH);
		scan_e = flow_tab[s];
		scan_exp = 1'b0;
		if (slot_used[s] && ((c_ts - scan_e.times[63:32]) >= inact_ms ||
				(c_ts - scan_e.times[31:0]) >= act_ms)) begin
			scan_exp = 1'b1;
			slot_used[s] = 1'b0;
		end
		scan_ptr = (s + 1) % DEPTH;
		pkt_count++;
		prior_coll = coll_count;

		if (captured) begin
			src = c_ips[63:32];
			dst = c_ips[31:0];
			h = src[31:16] ^ src[15:0] ^ dst[31:16] ^ dst[15:0] ^
				c_ports[31:16] ^ c_ports[15:0] ^ {8'h0, c_proto};
			a = 10'(h % DEPTH);
			fin = (c_flags & FIN_RST) != 0;
			pp = {c_proto, c_ports};
			hit_exp = fin;
			store = 1'b1;
			e = '0;
			e.addrs = c_ips;
			e.pp = pp;
			if (slot_used[a]) begin
				if (flow_tab[a].addrs == c_ips && flow_tab[a].pp == pp) begin
					bytes = flow_tab[a].counts[63:32] + c_len;
					pkts = flow_tab[a].counts[31:0] + 1;
					e.times = {c_ts, flow_tab[a].times[31:0]};
					e.counts = {bytes, pkts};
					e.flags = flow_tab[a].flags | c_flags;
				end else begin
					coll_count++;
					collisions_seen++;
					hit_exp = 1'b0;
					store = 1'b0;
				end
			end else begin
				e.times = {c_ts, c_ts};
				e.counts = {16'h0, c_len, 32'd1};
				e.flags = c_flags;
			end
			if (store) begin
				slot_used[a] = !fin;
				if (!fin)
					flow_tab[a] = e;
			end
			if (hit_exp)
				push_record(e);
		end
		if (scan_exp)
			push_record(scan_e);

		st = '0;
		st.is_status = 1'b1;
		st.processed_packets = pkt_count;
		st.collisions = prior_coll;
		st.run_end = 1'b1;
		expected_res.push_back(st);

		beat_pos = '0;
		dropping = 1'b0;
		captured = 1'b0;
	endtask

	task automatic check_result(input res_t r);
		res_t e;
		if (expected_res.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: word=%h status=%b", r.word, r.is_status);
			return;
		end
		e = expected_res.pop_front();
		if (r.is_status)
			packets_seen++;
		else if (r.record_end)
			records_seen++;
		if (r.word !== e.word || r.strobe_res !== e.strobe_res ||
				r.record_end !== e.record_end || r.is_status !== e.is_status ||
				r.processed_packets !== e.processed_packets ||
				r.collisions !== e.collisions || r.run_end !== e.run_end) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: exp word=%h strb=%h end=%b st=%b pkts=%0d coll=%0d run=%b",
					" / got word=%h strb=%h end=%b st=%b pkts=%0d coll=%0d run=%b"},
					e.word, e.strobe_res, e.record_end, e.is_status,
					e.processed_packets, e.collisions, e.run_end,
					r.word, r.strobe_res, r.record_end, r.is_status,
					r.processed_packets, r.collisions, r.run_end);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		packets_seen = 0;
		records_seen = 0;
		collisions_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inact_ms = INACT_RESET;
			act_ms = ACT_RESET;
			slot_used = '0;
			pkt_count = '0;
			coll_count = '0;
			scan_ptr = 0;
			beat_pos = '0;
			dropping = 1'b0;
			captured = 1'b0;
			c_ts = '0;
			c_len = '0;
			c_proto = '0;
			c_ips = '0;
			c_ports = '0;
			c_flags = '0;
			expected_res.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INACT)
					inact_ms = cfg_data;
				else
					act_ms = cfg_data;
			end
			if (beat_valid && beat_ready)
				meter_beat(beat);
			if (res_valid && res_ready)
				check_result(res);
		end
		pending = expected_res.size();
	end

endmodule

/* bench/ipv4_flow_meter_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_flow_meter_table_test
// Drives packets into the flow meter table: directed header cases, then
// random traffic over a small pool of flows with merges, slot collisions,
// FIN/RST closes and timeout exports, under several timeout settings and
// stall patterns. The scoreboard does prediction and comparison.
// ----------------------------------------------------------------------------
module ipv4_flow_meter_table_test;
	import ftab_pkg::*;

	typedef struct packed {
		logic [63:0] ips;
		logic [31:0] ports;
		logic [7:0]  proto;
	} flow_key_t;

	typedef enum int {PK_GOOD, PK_BAD_ETYPE, PK_BAD_VER, PK_BAD_PROTO, PK_SHORT, PK_NOISE}
		pkt_kind_t;

	logic        clk;
	logic        arst_n;
	logic        beat_valid, beat_ready;
	beat_t       beat;
	logic        res_valid, res_ready;
	res_t        res;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	int          errors, pending, packets_seen, records_seen, collisions_seen;
	int          send_idle_pct, recv_stall_pct, step_max;
	int          beats_sent;
	int unsigned cycles;
	logic [31:0] clock_ms;
	flow_key_t   flow_pool [8];

	ipv4_flow_meter_table DUT (
		.clk(clk), .arst_n(arst_n),
		.beat_valid(beat_valid), .beat_ready(beat_ready), .beat(beat),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	flow_meter_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.beat_valid(beat_valid), .beat_ready(beat_ready), .beat(beat),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .packets_seen(packets_seen),
		.records_seen(records_seen), .collisions_seen(collisions_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		res_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout with %0d results outstanding", pending);
			$display("status: fail");
			$finish;
		end
	end

	// key whose hash lands on a chosen low slot, so the scan reaches it early
	function automatic flow_key_t make_key(input logic [9:0] slot);
		flow_key_t k;
		logic [15:0] h;
		k.ips = {$urandom, $urandom};
		k.ips[15:0] = '0;
		k.ports = $urandom;
		if (k.ports[31:16] == k.ports[15:0])
			k.ports[0] = ~k.ports[0];
		k.proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		h = k.ips[63:48] ^ k.ips[47:32] ^ k.ips[31:16] ^ k.ports[31:16] ^
			k.ports[15:0] ^ {8'h0, k.proto};
		k.ips[15:0] = h ^ {6'h0, slot};
		return k;
	endfunction

	task automatic send_beat(input logic [63:0] d, input logic last, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			beat_valid <= 1'b0;
			@(posedge clk);
		end
		beat_valid <= 1'b1;
		beat <= '{beat_data: d, beat_last: last, now_ms: now};
		@(posedge clk);
		while (!beat_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_packet(input pkt_kind_t kind, input flow_key_t k,
			input logic [7:0] flags, input int n);
		logic [63:0] d [10];
		for (int i = 0; i < 10; i++)
			d[i] = {$urandom, $urandom};
		if (kind != PK_NOISE) begin
			d[1][39:32] = (kind == PK_BAD_ETYPE) ? 8'h86 : ETH_IPV4_HI;
			d[1][47:40] = ETH_IPV4_LO;
			d[1][55:48] = (kind == PK_BAD_VER) ? {4'h6, d[1][51:48]} : {4'h4, d[1][51:48]};
			d[2][15:0] = {d[2][7:0], d[2][15:8]} & 16'h07ff;
			d[2][63:56] = (kind == PK_BAD_PROTO) ? 8'd1 : k.proto;
			{d[3][23:16], d[3][31:24], d[3][39:32], d[3][47:40]} = k.ips[63:32];
			{d[3][55:48], d[3][63:56], d[4][7:0], d[4][15:8]} = k.ips[31:0];
			{d[4][23:16], d[4][31:24], d[4][39:32], d[4][47:40]} = k.ports;
			d[5][63:56] = flags;
		end
		for (int i = 0; i < n; i++)
			send_beat(d[i], i == n - 1, (i == 0) ? clock_ms : $urandom);
		clock_ms += $urandom_range(step_max);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		beat_valid <= 1'b0;
		// let the scoreboard take in the final accepted beat first
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_traffic(input int quota);
		int r;
		flow_key_t k;
		logic [7:0] fl;
		while (beats_sent < quota) begin
			r = $urandom_range(99);
			k = flow_pool[$urandom_range(7)];
			if ($urandom_range(9) == 0)
				k.ports = {k.ports[15:0], k.ports[31:16]};
			fl = 8'($urandom);
			r = $urandom_range(99);
			if (r < 8)
				send_packet(PK_NOISE, k, fl, $urandom_range(1, 9));
			else if (r < 12)
				send_packet(PK_BAD_ETYPE, k, fl, $urandom_range(2, 7));
			else if (r < 14)
				send_packet(PK_BAD_VER, k, fl, $urandom_range(2, 7));
			else if (r < 16)
				send_packet(PK_BAD_PROTO, k, fl, $urandom_range(3, 7));
			else if (r < 20)
				send_packet(PK_SHORT, k, fl, $urandom_range(1, 5));
			else begin
				r = $urandom_range(99);
				fl = (r < 10) ? 8'h01 : (r < 15) ? 8'h04 : (fl & ~FIN_RST);
				send_packet(PK_GOOD, k, fl, $urandom_range(6, 9));
			end
		end
	endtask

	initial begin
		flow_key_t k0, k1, k2;
		clk = 1'b0;
		arst_n = 1'b0;
		beat_valid = 1'b0;
		beat = '0;
		res_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INACT;
		cfg_data = '0;
		cycles = 0;
		beats_sent = 0;
		send_idle_pct = 20;
		recv_stall_pct = 73;
		step_max = 15;
		clock_ms = 32'd100;
		for (int i = 0; i < 8; i++)
			flow_pool[i] = make_key(10'($urandom_range(60)));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(REG_INACT, 32'd40);
		cfg_write(REG_ACT, 32'd300);

		// header checks, then new/merge/collision/close on a few flows
		k0 = make_key(10'd0);
		k1 = make_key(10'd1);
		k1.proto = PROTO_UDP;
		k2 = make_key(10'd2);
		k2.proto = PROTO_TCP;
		send_beat('1, 1'b1, '1);
		send_beat('0, 1'b1, '0);
		send_packet(PK_BAD_ETYPE, k0, 8'h0, 2);
		send_packet(PK_BAD_VER, k0, 8'h0, 2);
		send_packet(PK_BAD_PROTO, k0, 8'h0, 3);
		send_packet(PK_SHORT, k0, 8'h0, 5);
		k0.proto = PROTO_TCP;
		send_packet(PK_GOOD, k0, 8'h12, 6);
		send_packet(PK_GOOD, k0, 8'h10, 6);
		send_packet(PK_GOOD, '{ips: k0.ips, ports: {k0.ports[15:0], k0.ports[31:16]},
			proto: k0.proto}, 8'h10, 6);
		send_packet(PK_GOOD, k1, 8'hff, 6);
		send_packet(PK_GOOD, k0, 8'h01, 6);
		send_packet(PK_GOOD, k2, 8'h04, 6);
		random_traffic(130);
		drain();

		send_idle_pct = 73;
		recv_stall_pct = 20;
		cfg_write(REG_INACT, 32'd0);
		cfg_write(REG_ACT, 32'hffffffff);
		random_traffic(230);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_write(REG_INACT, 32'hffffffff);
		cfg_write(REG_ACT, 32'd0);
		random_traffic(320);
		drain();

		// time near the top of the range so differences wrap
		clock_ms = 32'hffffff80;
		step_max = 40;
		cfg_write(REG_INACT, 32'd60);
		cfg_write(REG_ACT, 32'hffffffff);
		random_traffic(420);
		drain();

		$display("%0d beats, %0d packets, %0d exported records, %0d slot collisions",
			beats_sent, packets_seen, records_seen, collisions_seen);
		$display("timeouts swept 0 to max; stalls on either side and none");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/ftab_pkg.sv
rtl/ftab_front.sv
rtl/ftab_fifo.sv
rtl/ftab_back.sv
rtl/ipv4_flow_meter_table.sv
bench/flow_meter_scoreboard.sv
bench/ipv4_flow_meter_table_test.sv
